[rtl/sdx_pkg.sv]
// shared types, constants and the letter class lookup for the soundex encoder
// no dependencies
package sdx_pkg;

  localparam int unsigned DIGITS = 3;
  localparam logic [5:0] PAD_CHAR = 6'h30;

  typedef logic [2:0] sdx_class_t;

  localparam sdx_class_t CLS_NONE  = 3'd0;
  localparam sdx_class_t CLS_LABIAL = 3'd1;
  localparam sdx_class_t CLS_GUTTURAL = 3'd2;
  localparam sdx_class_t CLS_DENTAL = 3'd3;
  localparam sdx_class_t CLS_L = 3'd4;
  localparam sdx_class_t CLS_NASAL = 3'd5;
  localparam sdx_class_t CLS_R = 3'd6;

  typedef struct packed {
    logic [7:0] lead_char;
    logic [5:0] digit_one;
    logic [5:0] digit_two;
    logic [5:0] digit_three;
    logic       no_word;
  } sdx_result_t;

  function automatic logic is_word_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || (c == "'");
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic sdx_class_t class_of(input logic [7:0] c);
    logic [7:0] l;
    sdx_class_t r;
    l = to_lower(c);
    case (l) inside
      "b", "f", "p", "v":                     r = CLS_LABIAL;
      "c", "g", "j", "k", "q", "s", "x", "z": r = CLS_GUTTURAL;
      "d", "t":                               r = CLS_DENTAL;
      "l":                                    r = CLS_L;
      "m", "n":                               r = CLS_NASAL;
      "r":                                    r = CLS_R;
      default:                                r = CLS_NONE;
    endcase
    return r;
  endfunction

endpackage

[rtl/sdx_in_if.sv]
// input channel: one text byte per transfer with an end-of-text mark
// no dependencies
interface sdx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

[rtl/sdx_out_if.sv]
// output channel: one four-character code per transfer
// no dependencies
interface sdx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] lead_char;
  logic [5:0] digit_one;
  logic [5:0] digit_two;
  logic [5:0] digit_three;
  logic       no_word;

  modport source (output valid, output lead_char, output digit_one, output digit_two,
                  output digit_three, output no_word, input ready);
  modport sink (input valid, input lead_char, input digit_one, input digit_two,
                input digit_three, input no_word, output ready);
endinterface

[rtl/soundex_first_word_encoder_top.sv]
// soundex encoder of the first word of a byte stream, top level
// depends on sdx_pkg, sdx_in_if, sdx_out_if
// the end-of-text result is registered in the output register, else in the skid
// throughput: one byte per cycle; result queue of two (output register plus skid)
// ready drops only while both queue entries hold a result
// reset (synchronous, rst high): word search restarts, queue empties
module soundex_first_word_encoder_top (
  input  logic      clk,
  input  logic      rst,
  sdx_in_if.sink    text,
  sdx_out_if.source code
);
  import sdx_pkg::*;

  localparam logic [1:0] PH_BEFORE = 2'd0;
  localparam logic [1:0] PH_IN     = 2'd1;
  localparam logic [1:0] PH_AFTER  = 2'd2;

  logic [1:0]  phase, phase_next;
  logic [7:0]  lead_store, lead_store_next;
  logic [1:0]  digit_count, digit_count_next;
  sdx_class_t  digit_store [DIGITS];
  sdx_class_t  digit_store_next [DIGITS];
  sdx_class_t  prior_class, prior_class_next;

  sdx_result_t head, skid, result;
  logic        head_valid, skid_valid;

  logic        accept, push, pop, word;
  sdx_class_t  cur;

  assign text.ready = !skid_valid;
  assign accept     = text.valid && text.ready;
  assign push       = accept && text.end_of_text;
  assign pop        = head_valid && code.ready;
  assign word       = is_word_char(text.text_byte);
  assign cur        = class_of(text.text_byte);

  always_comb begin
    phase_next       = phase;
    lead_store_next  = lead_store;
    digit_count_next = digit_count;
    prior_class_next = prior_class;
    for (int i = 0; i < DIGITS; i++) digit_store_next[i] = digit_store[i];
    unique case (phase)
      PH_BEFORE: begin
        if (word) begin
          lead_store_next  = to_upper(to_lower(text.text_byte));
          prior_class_next = cur;
          digit_count_next = 2'd0;
          phase_next       = PH_IN;
        end
      end
      PH_IN: begin
        if (!word) begin
          phase_next = PH_AFTER;
        end else if (digit_count < 2'(DIGITS)) begin
          if (cur != CLS_NONE && cur != prior_class) begin
            digit_store_next[digit_count] = cur;
            digit_count_next = digit_count + 2'd1;
          end
          prior_class_next = cur;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (phase_next == PH_BEFORE) begin
      result = '{lead_char: 8'd0, digit_one: 6'd0, digit_two: 6'd0,
                 digit_three: 6'd0, no_word: 1'b1};
    end else begin
      result.lead_char   = lead_store_next;
      result.digit_one   = (digit_count_next > 2'd0) ?
                           (PAD_CHAR | 6'(digit_store_next[0])) : PAD_CHAR;
      result.digit_two   = (digit_count_next > 2'd1) ?
                           (PAD_CHAR | 6'(digit_store_next[1])) : PAD_CHAR;
      result.digit_three = (digit_count_next > 2'd2) ?
                           (PAD_CHAR | 6'(digit_store_next[2])) : PAD_CHAR;
      result.no_word     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_BEFORE;
      digit_count <= 2'd0;
      prior_class <= CLS_NONE;
      lead_store  <= 8'd0;
    end else if (accept) begin
      if (text.end_of_text) begin
        phase       <= PH_BEFORE;
        digit_count <= 2'd0;
        prior_class <= CLS_NONE;
        lead_store  <= 8'd0;
      end else begin
        phase       <= phase_next;
        digit_count <= digit_count_next;
        prior_class <= prior_class_next;
        lead_store  <= lead_store_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < DIGITS; i++) digit_store[i] <= digit_store_next[i];
    end
  end

  // two-entry result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (push) begin
        if (!head_valid || pop) begin
          head_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (pop) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          head_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!head_valid || pop) begin
        head <= result;
      end else begin
        skid <= result;
      end
    end else if (pop && skid_valid) begin
      head <= skid;
    end
  end

  assign code.valid       = head_valid;
  assign code.lead_char   = head.lead_char;
  assign code.digit_one   = head.digit_one;
  assign code.digit_two   = head.digit_two;
  assign code.digit_three = head.digit_three;
  assign code.no_word     = head.no_word;

endmodule

[rtl/sdx_checker.sv]
// port-level checks of the soundex encoder and the bind that attaches them
// depends on sdx_pkg and soundex_first_word_encoder_top
module sdx_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] lead_char,
  input logic [5:0] digit_one,
  input logic [5:0] digit_two,
  input logic [5:0] digit_three,
  input logic       no_word
);
  import sdx_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(lead_char) && $stable(digit_one)
      && $stable(digit_two) && $stable(digit_three) && $stable(no_word))
    else $error("stalled result changed");

  // a no-word result carries an all-zero code
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_word |-> lead_char == 8'd0 && digit_one == 6'd0
      && digit_two == 6'd0 && digit_three == 6'd0)
    else $error("no-word result carries a code");

  // code digits stay in the digit range
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !no_word |-> digit_one >= PAD_CHAR && digit_one <= 6'd54
      && digit_two >= PAD_CHAR && digit_two <= 6'd54
      && digit_three >= PAD_CHAR && digit_three <= 6'd54)
    else $error("code digit out of range");

  // padding only at the tail
  a_pad: assert property (@(posedge clk) disable iff (rst)
    out_valid && !no_word && (digit_one == PAD_CHAR || digit_two == PAD_CHAR)
      |-> digit_three == PAD_CHAR && (digit_one != PAD_CHAR || digit_two == PAD_CHAR))
    else $error("padding before a digit");

endmodule

bind soundex_first_word_encoder_top sdx_checker u_sdx_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (code.valid),
  .out_ready  (code.ready),
  .lead_char  (code.lead_char),
  .digit_one  (code.digit_one),
  .digit_two  (code.digit_two),
  .digit_three(code.digit_three),
  .no_word    (code.no_word)
);

[verif/sdx_code_checker.sv]
`timescale 1ns / 100ps
// checker for the soundex first-word encoder: follows every text transfer, predicts the
// code it leads to and compares each code transfer. depends on sdx_pkg, sdx_in_if, sdx_out_if
module sdx_code_checker (
  input  logic        clk,
  input  logic        rst,
  sdx_in_if           text,
  sdx_out_if          code,
  output int unsigned errors,
  output int unsigned pending
);
  import sdx_pkg::*;

  typedef enum logic [1:0] {SEEK, IN_WORD, PAST_WORD} scan_t;

  localparam sdx_class_t LETTER_CLASS [26] = '{
    CLS_NONE, CLS_LABIAL, CLS_GUTTURAL, CLS_DENTAL, CLS_NONE, CLS_LABIAL, CLS_GUTTURAL,
    CLS_NONE, CLS_NONE, CLS_GUTTURAL, CLS_GUTTURAL, CLS_L, CLS_NASAL, CLS_NASAL,
    CLS_NONE, CLS_LABIAL, CLS_GUTTURAL, CLS_R, CLS_GUTTURAL, CLS_DENTAL, CLS_NONE,
    CLS_LABIAL, CLS_NONE, CLS_GUTTURAL, CLS_NONE, CLS_GUTTURAL
  };

  scan_t       scan = SEEK;
  logic [7:0]  lead = 8'h00;
  int unsigned ndig = 0;
  sdx_class_t  digs [DIGITS];
  sdx_class_t  prior = CLS_NONE;
  int unsigned err_cnt = 0;
  sdx_result_t code_q [$];

  // letters fold onto lower case by setting bit 5, nothing else lands in a..z
  function automatic logic [7:0] folded(input logic [7:0] c);
    return c | 8'h20;
  endfunction

  function automatic bit wordish(input logic [7:0] c);
    logic [7:0] f;
    f = folded(c);
    return (f >= "a" && f <= "z") || (c >= "0" && c <= "9") || (c == 8'h27);
  endfunction

  function automatic sdx_class_t class_code(input logic [7:0] c);
    logic [7:0] f;
    f = folded(c);
    if (f >= "a" && f <= "z") return LETTER_CLASS[int'(f - 8'h61)];
    return CLS_NONE;
  endfunction

  function automatic logic [5:0] code_digit(input int unsigned k);
    if (k < ndig) return PAD_CHAR + 6'(digs[k]);
    return PAD_CHAR;
  endfunction

  task automatic clear_scan();
    scan = SEEK;
    lead = 8'h00;
    ndig = 0;
    prior = CLS_NONE;
    foreach (digs[i]) digs[i] = CLS_NONE;
  endtask

  task automatic take_byte(input logic [7:0] c, input logic last);
    sdx_class_t  k;
    sdx_result_t r;
    k = class_code(c);
    case (scan)
      SEEK: begin
        if (wordish(c)) begin
          lead = (c >= "a" && c <= "z") ? (c & 8'hDF) : c;
          prior = k;
          ndig = 0;
          scan = IN_WORD;
        end
      end
      IN_WORD: begin
        if (!wordish(c)) begin
          scan = PAST_WORD;
        end else if (ndig < DIGITS) begin
          if (k != CLS_NONE && k != prior) begin
            digs[ndig] = k;
            ndig++;
          end
          prior = k;
        end
      end
      default: ;
    endcase
    if (last) begin
      if (scan == SEEK) begin
        r = '{8'h00, 6'h00, 6'h00, 6'h00, 1'b1};
      end else begin
        r = '{lead, code_digit(0), code_digit(1), code_digit(2), 1'b0};
      end
      code_q = {code_q, r};
      clear_scan();
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    sdx_result_t want;
    if (rst) begin
      clear_scan();
      code_q.delete();
    end else begin
      if (code.valid && code.ready) begin
        if (code_q.size() == 0) begin
          err_cnt++;
          $display("%0t: code transfer with none expected, expected none, actual %h %h %h %h %b",
                   $time, code.lead_char, code.digit_one, code.digit_two, code.digit_three,
                   code.no_word);
        end else begin
          want = code_q.pop_front();
          check_field("lead_char", want.lead_char, code.lead_char);
          check_field("digit_one", 8'(want.digit_one), 8'(code.digit_one));
          check_field("digit_two", 8'(want.digit_two), 8'(code.digit_two));
          check_field("digit_three", 8'(want.digit_three), 8'(code.digit_three));
          check_field("no_word", 8'(want.no_word), 8'(code.no_word));
        end
      end
      if (text.valid && text.ready) take_byte(text.text_byte, text.end_of_text);
    end
    errors <= err_cnt;
    pending <= code_q.size();
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// testbench top for the soundex first-word encoder: clock, reset, text stimulus,
// random stalls on the code channel and the verdict. depends on the encoder top,
// sdx_in_if, sdx_out_if and sdx_code_checker
module tb;

  typedef logic [7:0] byte_q_t [$];

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TEXT_BYTES = 1100;
  localparam int unsigned CALM_FROM = 950;
  localparam string FILLER = " ,.;:-!?\"()@[`{/~";

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned errors;
  int unsigned pending;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  bit          calm = 1'b0;
  bit          idle_on = 1'b1;

  sdx_in_if  text_ch ();
  sdx_out_if code_ch ();

  soundex_first_word_encoder_top u_dut (
    .clk  (clk),
    .rst  (rst),
    .text (text_ch),
    .code (code_ch)
  );

  sdx_code_checker u_chk (
    .clk     (clk),
    .rst     (rst),
    .text    (text_ch),
    .code    (code_ch),
    .errors  (errors),
    .pending (pending)
  );

  always #6 clk = ~clk;

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // stalls on the code side
  initial begin
    code_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        code_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      code_ch.ready <= 1'b1;
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    if (!calm && idle_on && $urandom_range(0, 5) == 0) begin
      text_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    text_ch.valid <= 1'b1;
    text_ch.text_byte <= b;
    text_ch.end_of_text <= last;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_text(input byte_q_t t);
    for (int i = 0; i < t.size(); i++) put_byte(t[i], i == t.size() - 1);
  endtask

  task automatic drain();
    @(negedge clk);
    text_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic byte_q_t text_of(input string s);
    byte_q_t t;
    for (int i = 0; i < s.len(); i++) t = {t, 8'(s[i])};
    return t;
  endfunction

  function automatic logic [7:0] filler_byte();
    if ($urandom_range(0, 1) == 1) return 8'($urandom_range(128, 255));
    return FILLER[$urandom_range(0, FILLER.len() - 1)];
  endfunction

  function automatic logic [7:0] word_byte();
    case ($urandom_range(0, 19))
      0: return 8'($urandom_range(8'h30, 8'h39));
      1: return 8'h27;
      default: begin
        if ($urandom_range(0, 1) == 1) return 8'($urandom_range(8'h41, 8'h5A));
        return 8'($urandom_range(8'h61, 8'h7A));
      end
    endcase
  endfunction

  function automatic byte_q_t random_text();
    byte_q_t t;
    int unsigned n;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) t = {t, 8'($urandom)};
    end else begin
      repeat ($urandom_range(0, 3)) t = {t, filler_byte()};
      repeat ($urandom_range(1, 9)) t = {t, word_byte()};
      n = $urandom_range(0, 3);
      if (n > 0) begin
        t = {t, filler_byte()};
        repeat (n - 1) t = {t, 8'($urandom)};
      end
    end
    return t;
  endfunction

  initial begin
    string   words [$];
    byte_q_t txt;
    words = '{"z", "'9", "Rbcdlm", "Tbbhb", "Bbv", "Ab c"};
    text_ch.valid = 1'b0;
    text_ch.text_byte = 8'h00;
    text_ch.end_of_text = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    txt = {8'h00};
    send_text(txt);
    txt = {8'hFF};
    send_text(txt);
    foreach (words[i]) send_text(text_of(words[i]));

    // hold off until the directed codes are all back
    drain();

    while (sent < TEXT_BYTES) begin
      if (sent >= CALM_FROM) calm = 1'b1;
      if ($urandom_range(0, 3) == 0) idle_on = ~idle_on;
      send_text(random_text());
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
